// ----- rtl/adpcm_four_voice_sample_player_macros.svh -----
// Assertion macros for the sample player
`ifndef ADPCM_FOUR_VOICE_SAMPLE_PLAYER_MACROS_SVH
`define ADPCM_FOUR_VOICE_SAMPLE_PLAYER_MACROS_SVH
// assert a property that holds outside reset
`define AFV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert that a signal never goes unknown outside reset
`define AFV_KNOWN(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);
`endif

// ----- rtl/afv_pkg.sv -----
// Types, constants and tables for the sample player
package afv_pkg;
    localparam int RATE_W = 27;
    localparam int SIZE_W = 19;
    localparam int ACC_W  = 28;

    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_LOAD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_TICK   = 2'd0,
        CFG_DECODE = 2'd1,
        CFG_OUTPUT = 2'd2,
        CFG_SIZE   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_PH_ADDR,
        ST_PH_WAIT,
        ST_PH_READ,
        ST_PH_CHECK,
        ST_ACC,
        ST_V_ADDR,
        ST_V_WAIT,
        ST_V_DECODE,
        ST_MIX,
        ST_OUT_ACC,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       take_item;
        logic       cmd_exec;
        logic       rom_write;
        logic       ph_addr;
        logic [2:0] ph_byte;
        logic       ph_capture;
        logic       ph_commit;
        logic       dec_acc;
        logic       v_addr;
        logic       v_decode;
        logic       v_clear_mix;
        logic       mix_commit;
        logic       out_acc;
        logic       load_status;
        logic       load_sample;
        logic [1:0] voice;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       start_go;
        logic       dec_fire;
        logic       out_fire;
    } stat_t;

    function automatic logic [10:0] step_lookup(input logic [5:0] i);
        logic [10:0] r;
        unique case (i)
            6'd0: r = 11'd16;    6'd1: r = 11'd17;    6'd2: r = 11'd19;
            6'd3: r = 11'd21;    6'd4: r = 11'd23;    6'd5: r = 11'd25;
            6'd6: r = 11'd28;    6'd7: r = 11'd31;    6'd8: r = 11'd34;
            6'd9: r = 11'd37;    6'd10: r = 11'd41;   6'd11: r = 11'd45;
            6'd12: r = 11'd50;   6'd13: r = 11'd55;   6'd14: r = 11'd60;
            6'd15: r = 11'd66;   6'd16: r = 11'd73;   6'd17: r = 11'd80;
            6'd18: r = 11'd88;   6'd19: r = 11'd97;   6'd20: r = 11'd107;
            6'd21: r = 11'd118;  6'd22: r = 11'd130;  6'd23: r = 11'd143;
            6'd24: r = 11'd157;  6'd25: r = 11'd173;  6'd26: r = 11'd190;
            6'd27: r = 11'd209;  6'd28: r = 11'd230;  6'd29: r = 11'd253;
            6'd30: r = 11'd279;  6'd31: r = 11'd307;  6'd32: r = 11'd337;
            6'd33: r = 11'd371;  6'd34: r = 11'd408;  6'd35: r = 11'd449;
            6'd36: r = 11'd494;  6'd37: r = 11'd544;  6'd38: r = 11'd598;
            6'd39: r = 11'd658;  6'd40: r = 11'd724;  6'd41: r = 11'd796;
            6'd42: r = 11'd876;  6'd43: r = 11'd963;  6'd44: r = 11'd1060;
            6'd45: r = 11'd1166; 6'd46: r = 11'd1282; 6'd47: r = 11'd1411;
            default: r = 11'd1552;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] gain_lookup(input logic [3:0] a);
        logic [15:0] r;
        unique case (a)
            4'd0: r = 16'd32768; 4'd1: r = 16'd22669; 4'd2: r = 16'd16423;
            4'd3: r = 16'd11361; 4'd4: r = 16'd8231;  4'd5: r = 16'd6173;
            4'd6: r = 16'd4125;  4'd7: r = 16'd3093;  default: r = 16'd2068;
        endcase
        return r;
    endfunction
endpackage

// ----- rtl/afv_stream_if.sv -----
// Valid/ready channel interface
interface afv_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/adpcm_four_voice_sample_player.sv -----
// Top level of the four-voice ADPCM sample player
// Usage:
//   in  : one word per item (mode, data_byte, rom_address); taken on valid and ready.
//   out : one word per status read and per output strobe (is_sample,
//         playing_mask, mix_sample); held until ready.
//   cfg : write enable, register index and data; write only while idle.
// Steps per item:
//   rom load writes the byte; stop or first start byte is executed; second start byte
//   fetches six phrase bytes in turn through the single ROM port (address, wait, read),
//   then checks and commits; status read loads the result and waits for output; a tick
//   steps the decode accumulator, decodes each voice in turn on the ROM port (address,
//   wait, decode) and mixes when decode fires, then steps the output accumulator and waits for output when it strobes.
// The controller takes one item at a time; the next is accepted when the
// previous result has been taken.
// Reset: voices stop, accumulators and mix clear, registers return to defaults;
// the sample ROM is not cleared and must be loaded before use.
// A stalled receiver holds the result word and blocks further input.
module adpcm_four_voice_sample_player #(
    parameter int ROM_ADDR_BITS = 18,
    parameter int NUM_VOICES    = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    afv_stream_if.sink               in_ch,
    afv_stream_if.source             out_ch,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [afv_pkg::RATE_W-1:0] cfg_data
);
    import afv_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic  is_sample;
    logic [3:0] playing_mask;
    logic signed [15:0] mix_sample;

    afv_ctrl #(.NUM_VOICES(NUM_VOICES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    afv_datapath #(.ROM_ADDR_BITS(ROM_ADDR_BITS), .NUM_VOICES(NUM_VOICES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (in_ch.payload[27:26]),
        .data_byte    (in_ch.payload[25:18]),
        .rom_address  (in_ch.payload[17:0]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .stat         (stat),
        .is_sample    (is_sample),
        .playing_mask (playing_mask),
        .mix_sample   (mix_sample)
    );

    assign out_ch.payload = {is_sample, playing_mask, mix_sample};

`include "adpcm_four_voice_sample_player_macros.svh"

    `AFV_ASSERT(a_no_both, !(in_ch.ready && out_ch.valid), "input taken while result pending")
    `AFV_ASSERT(a_status_zero, (out_ch.valid && !out_ch.payload[20]) |-> (out_ch.payload[15:0] == 16'd0), "status word carries mix")
    `AFV_KNOWN(a_known_valid, out_ch.valid, "result valid unknown")
endmodule

// ----- rtl/afv_ram.sv -----
// Generic single-port RAM with registered read
module afv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/afv_ctrl.sv -----
// Controller state machine for the sample player
module afv_ctrl #(
    parameter int NUM_VOICES = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  afv_pkg::stat_t stat,
    output afv_pkg::ctrl_t ctrl
);
    import afv_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] voice_reg, voice_next;
    logic [2:0] pb_reg, pb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            voice_reg <= '0;
            pb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            voice_reg <= voice_next;
            pb_reg    <= pb_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        voice_next = voice_reg;
        pb_next    = pb_reg;
        ctrl       = '0;
        ctrl.voice   = voice_reg;
        ctrl.ph_byte = pb_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.take_item = 1'b1;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                voice_next = '0;
                pb_next    = '0;
                unique case (mode_t'(stat.mode))
                    MODE_CMD:
                    begin
                        ctrl.cmd_exec = 1'b1;
                        state_next = stat.start_go ? ST_PH_ADDR : ST_IDLE;
                    end
                    MODE_STATUS:
                    begin
                        ctrl.load_status = 1'b1;
                        state_next = ST_RESULT;
                    end
                    MODE_LOAD:
                    begin
                        ctrl.rom_write = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_ACC;
                    end
                endcase
            end
            ST_PH_ADDR:
            begin
                ctrl.ph_addr = 1'b1;
                state_next = ST_PH_WAIT;
            end
            ST_PH_WAIT:
            begin
                ctrl.ph_addr = 1'b1;
                state_next = ST_PH_READ;
            end
            ST_PH_READ:
            begin
                ctrl.ph_capture = 1'b1;
                if (pb_reg == 3'd5)
                begin
                    state_next = ST_PH_CHECK;
                end
                else
                begin
                    pb_next = pb_reg + 3'd1;
                    state_next = ST_PH_ADDR;
                end
            end
            ST_PH_CHECK:
            begin
                ctrl.ph_commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ACC:
            begin
                ctrl.dec_acc = 1'b1;
                ctrl.v_clear_mix = 1'b1;
                state_next = stat.dec_fire ? ST_V_ADDR : ST_OUT_ACC;
            end
            ST_V_ADDR:
            begin
                ctrl.v_addr = 1'b1;
                state_next = ST_V_WAIT;
            end
            ST_V_WAIT:
            begin
                ctrl.v_addr = 1'b1;
                state_next = ST_V_DECODE;
            end
            ST_V_DECODE:
            begin
                ctrl.v_decode = 1'b1;
                if (32'(voice_reg) == NUM_VOICES - 1)
                begin
                    state_next = ST_MIX;
                end
                else
                begin
                    voice_next = voice_reg + 2'd1;
                    state_next = ST_V_ADDR;
                end
            end
            ST_MIX:
            begin
                ctrl.mix_commit = 1'b1;
                state_next = ST_OUT_ACC;
            end
            ST_OUT_ACC:
            begin
                ctrl.out_acc = 1'b1;
                if (stat.out_fire)
                begin
                    ctrl.load_sample = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/afv_datapath.sv -----
// Datapath: ROM, voice state, decoder, mixer and rate accumulators
module afv_datapath #(
    parameter int ROM_ADDR_BITS = 18,
    parameter int NUM_VOICES    = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                mode,
    input  logic [7:0]                data_byte,
    input  logic [17:0]               rom_address,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [afv_pkg::RATE_W-1:0] cfg_data,
    input  afv_pkg::ctrl_t            ctrl,
    output afv_pkg::stat_t            stat,
    output logic                      is_sample,
    output logic [3:0]                playing_mask,
    output logic signed [15:0]        mix_sample
);
    import afv_pkg::*;

    localparam int NV = NUM_VOICES;

    logic [RATE_W-1:0] tick_reg, dec_rate_reg, out_rate_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  data_reg;
    logic [17:0] addr_reg;

    logic [17:0] pos_reg [NV];
    logic [17:0] end_reg [NV];
    logic        low_reg [NV];
    logic signed [11:0] lvl_reg [NV];
    logic [5:0]  idx_reg [NV];
    logic [3:0]  att_reg [NV];
    logic [NV-1:0] act_reg;

    logic        pend_reg;
    logic [6:0]  phrase_reg;
    logic [ACC_W-1:0] dacc_reg, oacc_reg;
    logic signed [15:0] held_reg;
    logic signed [19:0] mix_reg;
    logic [3:0]  vmask_reg;
    logic [3:0]  vatt_reg;
    logic [7:0]  ph_reg [6];

    logic        res_is_reg;
    logic [3:0]  res_mask_reg;
    logic signed [15:0] res_mix_reg;

    logic                     rom_we;
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic [7:0]               rom_rdata;

    afv_ram #(.WIDTH(8), .DEPTH(1 << ROM_ADDR_BITS)) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .addr  (rom_addr),
        .wdata (data_reg),
        .rdata (rom_rdata)
    );

    logic [19:0] ph_base;
    assign ph_base = {10'd0, phrase_reg, 3'd0};

    always_comb
    begin
        rom_we   = ctrl.rom_write;
        rom_addr = addr_reg[ROM_ADDR_BITS-1:0];
        if (ctrl.ph_addr)
        begin
            rom_addr = ROM_ADDR_BITS'(ph_base + {17'd0, ctrl.ph_byte});
        end
        else if (ctrl.v_addr)
        begin
            rom_addr = pos_reg[ctrl.voice][ROM_ADDR_BITS-1:0];
        end
    end

    // rate accumulator step
    function automatic logic [ACC_W:0] acc_step(input logic [ACC_W-1:0] acc,
                                                 input logic [RATE_W-1:0] rate,
                                                 input logic [RATE_W-1:0] tick);
        logic [ACC_W-1:0] den, s, d;
        logic             f;
        den = (tick == '0) ? ACC_W'(1) : ACC_W'(tick);
        s = acc + ACC_W'(rate);
        f = 1'b0;
        if (s >= den)
        begin
            d = s - den;
            f = 1'b1;
            if (d >= den)
            begin
                d = den - ACC_W'(1);
            end
            s = d;
        end
        return {f, s};
    endfunction

    logic [ACC_W:0] dacc_new, oacc_new;
    assign dacc_new = acc_step(dacc_reg, dec_rate_reg, tick_reg);
    assign oacc_new = acc_step(oacc_reg, out_rate_reg, tick_reg);

    // phrase entry range checks
    logic [17:0] sa, ea;
    logic        ph_fits, ph_bad;
    assign sa = {ph_reg[0][1:0], ph_reg[1], ph_reg[2]};
    assign ea = {ph_reg[3][1:0], ph_reg[4], ph_reg[5]};
    assign ph_fits = ({1'b0, ph_base} + 21'd6) <= {2'd0, size_reg};
    assign ph_bad  = (sa > ea) || ({1'b0, ea} >= size_reg);

    // voice decode
    logic [1:0]  dv;
    logic        d_beyond;
    logic [3:0]  nib;
    logic [10:0] step;
    logic [11:0] diff;
    logic signed [13:0] lvl_sum;
    logic signed [11:0] lvl_new;
    logic signed [7:0]  idx_sum;
    logic [5:0]  idx_new, idx_cur;
    logic signed [11:0] lvl_eff;
    logic signed [28:0] prod;
    logic signed [15:0] scaled;

    assign dv = ctrl.voice;

    always_comb
    begin
        d_beyond = {1'b0, pos_reg[dv]} >= size_reg;
        nib      = low_reg[dv] ? rom_rdata[3:0] : rom_rdata[7:4];
        idx_cur  = (idx_reg[dv] > 6'd48) ? 6'd48 : idx_reg[dv];
        step     = step_lookup(idx_cur);
        diff     = {4'd0, step[10:3]};
        if (nib[2]) diff = diff + {1'b0, step};
        if (nib[1]) diff = diff + {2'd0, step[10:1]};
        if (nib[0]) diff = diff + {3'd0, step[10:2]};
        lvl_sum  = nib[3] ? (14'(lvl_reg[dv]) - $signed({2'b00, diff}))
                          : (14'(lvl_reg[dv]) + $signed({2'b00, diff}));
        if (lvl_sum > 14'sd2047) lvl_new = 12'sd2047;
        else if (lvl_sum < -14'sd2048) lvl_new = -12'sd2048;
        else lvl_new = lvl_sum[11:0];
        idx_sum = $signed({2'b00, idx_cur}) + (nib[2] ?
                  $signed({4'd0, nib[1:0], 1'b0} + 8'd2) : -8'sd1);
        if (idx_sum < 0) idx_new = 6'd0;
        else if (idx_sum > 8'sd48) idx_new = 6'd48;
        else idx_new = idx_sum[5:0];
        // level after this voice's step, for the mix
        lvl_eff = lvl_reg[dv];
        if (act_reg[dv])
        begin
            if (d_beyond) lvl_eff = '0;
            else if (low_reg[dv] && pos_reg[dv] >= end_reg[dv]) lvl_eff = '0;
            else lvl_eff = lvl_new;
        end
        prod   = 29'(lvl_eff) * $signed({1'b0, gain_lookup(att_reg[dv])});
        scaled = 16'(prod >>> 13);
    end

    logic signed [19:0] mix_sum;
    assign mix_sum = mix_reg + 20'(scaled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= RATE_W'(1000000);
            dec_rate_reg <= RATE_W'(7575);
            out_rate_reg <= RATE_W'(44100);
            size_reg     <= SIZE_W'(262144);
            for (int v = 0; v < NV; v++)
            begin
                pos_reg[v] <= '0;
                end_reg[v] <= '0;
                low_reg[v] <= 1'b0;
                lvl_reg[v] <= '0;
                idx_reg[v] <= '0;
                att_reg[v] <= '0;
            end
            act_reg      <= '0;
            pend_reg     <= 1'b0;
            phrase_reg   <= '0;
            dacc_reg     <= '0;
            oacc_reg     <= '0;
            held_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_TICK:   tick_reg     <= cfg_data;
                    CFG_DECODE: dec_rate_reg <= cfg_data;
                    CFG_OUTPUT: out_rate_reg <= cfg_data;
                    default:    size_reg     <= cfg_data[SIZE_W-1:0];
                endcase
            end
            if (ctrl.cmd_exec)
            begin
                if (pend_reg)
                begin
                    pend_reg <= 1'b0;
                end
                else if (data_reg[7])
                begin
                    if (data_reg[6:0] != 7'd0)
                    begin
                        phrase_reg <= data_reg[6:0];
                        pend_reg   <= 1'b1;
                    end
                end
                else
                begin
                    for (int v = 0; v < NV; v++)
                    begin
                        if (data_reg[4+v])
                        begin
                            act_reg[v] <= 1'b0;
                            lvl_reg[v] <= '0;
                        end
                    end
                end
            end
            if (ctrl.ph_commit && ph_fits)
            begin
                for (int v = 0; v < NV; v++)
                begin
                    if (vmask_reg[v])
                    begin
                        lvl_reg[v] <= '0;
                        if (ph_bad)
                        begin
                            act_reg[v] <= 1'b0;
                        end
                        else
                        begin
                            pos_reg[v] <= sa;
                            end_reg[v] <= ea;
                            low_reg[v] <= 1'b0;
                            idx_reg[v] <= '0;
                            att_reg[v] <= (vatt_reg > 4'd8) ? 4'd8 : vatt_reg;
                            act_reg[v] <= 1'b1;
                        end
                    end
                end
            end
            if (ctrl.dec_acc)
            begin
                dacc_reg <= dacc_new[ACC_W-1:0];
            end
            if (ctrl.out_acc)
            begin
                oacc_reg <= oacc_new[ACC_W-1:0];
            end
            if (ctrl.v_decode && act_reg[dv])
            begin
                if (d_beyond)
                begin
                    act_reg[dv] <= 1'b0;
                    lvl_reg[dv] <= '0;
                end
                else
                begin
                    lvl_reg[dv] <= lvl_new;
                    idx_reg[dv] <= idx_new;
                    if (low_reg[dv] && pos_reg[dv] >= end_reg[dv])
                    begin
                        act_reg[dv] <= 1'b0;
                        lvl_reg[dv] <= '0;
                    end
                    else
                    begin
                        if (low_reg[dv])
                        begin
                            pos_reg[dv] <= pos_reg[dv] + 18'd1;
                        end
                        low_reg[dv] <= !low_reg[dv];
                    end
                end
            end
            if (ctrl.mix_commit)
            begin
                if (mix_reg > 20'sd32767) held_reg <= 16'sd32767;
                else if (mix_reg < -20'sd32768) held_reg <= -16'sd32768;
                else held_reg <= mix_reg[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take_item)
        begin
            mode_reg <= mode;
            data_reg <= data_byte;
            addr_reg <= rom_address;
        end
        if (ctrl.cmd_exec && pend_reg)
        begin
            vmask_reg <= data_reg[7:4];
            vatt_reg  <= data_reg[3:0];
        end
        if (ctrl.ph_capture)
        begin
            ph_reg[ctrl.ph_byte] <= rom_rdata;
        end
        if (ctrl.v_clear_mix)
        begin
            mix_reg <= '0;
        end
        else if (ctrl.v_decode)
        begin
            mix_reg <= mix_sum;
        end
        if (ctrl.load_status || ctrl.load_sample)
        begin
            res_is_reg   <= ctrl.load_sample;
            res_mask_reg <= 4'(act_reg);
            res_mix_reg  <= ctrl.load_sample ? held_reg : 16'sd0;
        end
    end

    // a start word fires the phrase fetch when any implemented voice is selected
    assign stat.mode     = mode_reg;
    assign stat.start_go = pend_reg && ((data_reg[7:4] & 4'(act_reg | ~act_reg)) != 4'd0);
    assign stat.dec_fire = dacc_new[ACC_W];
    assign stat.out_fire = oacc_new[ACC_W];

    assign is_sample    = res_is_reg;
    assign playing_mask = res_mask_reg;
    assign mix_sample   = res_mix_reg;
endmodule
